[hw/rtl/dlq_pkg.sv]
package dlq_pkg;

  // Default list depth.
  localparam int DEPTH_DEF = 16;

  // Most results that one tick may fire.
  localparam int MAX_RESULTS = 16;
  localparam int NRES_W = $clog2(MAX_RESULTS + 1);

  // Field widths.
  localparam int ID_W = 8;
  localparam int DELAY_W = 16;
  localparam int KIND_W = 2;

  typedef logic [ID_W-1:0] id_t;
  typedef logic [DELAY_W-1:0] delay_t;
  typedef logic [KIND_W-1:0] kind_t;

  localparam delay_t DELAY_MAX = {DELAY_W{1'b1}};

  // Request types.
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_ADD = 1'b1;

  // Result kinds.
  localparam kind_t KIND_NONE = 2'd0;
  localparam kind_t KIND_ACCEPT = 2'd1;
  localparam kind_t KIND_FIRED = 2'd2;
  localparam kind_t KIND_FULL = 2'd3;

endpackage

[hw/rtl/dlq_req_if.sv]
interface dlq_req_if import dlq_pkg::*; ();
  logic valid;
  logic ready;
  logic req_type;
  id_t event_id;
  delay_t delay;

  modport source(output valid, req_type, event_id, delay, input ready);
  modport sink(input valid, req_type, event_id, delay, output ready);
endinterface

[hw/rtl/dlq_rsp_if.sv]
interface dlq_rsp_if import dlq_pkg::*; ();
  logic valid;
  logic ready;
  kind_t kind;
  id_t fired_id;
  logic last;

  modport source(output valid, kind, fired_id, last, input ready);
  modport sink(input valid, kind, fired_id, last, output ready);
endinterface

[hw/rtl/delta_list_timer_queue.sv]
// An add walks over the stored deltas and then shifts the entries behind the insert
// point; the walk and the shift both go through the one memory port.
// Throughput: one request word at a time; the next is taken once the last result word
// of the current one sits in the output register.
// Reset (synchronous, active high) empties the list, clears the tick counter and drops
// any pending result word; no clearing pass is needed.
module delta_list_timer_queue import dlq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input logic clk,
  input logic rst,
  dlq_req_if.sink req,
  dlq_rsp_if.source rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = DELAY_W + CW + 2;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic signed [SW-1:0] SAT_HI = SW'(DELAY_MAX);

  // Sequencer states.
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_EMIT = 4'd1;
  localparam logic [3:0] ST_WALK = 4'd2;
  localparam logic [3:0] ST_CALC_NEW = 4'd3;
  localparam logic [3:0] ST_CALC_FOL = 4'd4;
  localparam logic [3:0] ST_SHIFT_PRIME = 4'd5;
  localparam logic [3:0] ST_SHIFT = 4'd6;
  localparam logic [3:0] ST_WR_FOL = 4'd7;
  localparam logic [3:0] ST_WR_NEW = 4'd8;
  localparam logic [3:0] ST_TICK = 4'd9;
  localparam logic [3:0] ST_POP = 4'd10;

  // Logical list index to physical slot of the circular buffer.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] l);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(l);
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  // Clamp a signed difference into the delta range.
  function automatic delay_t sat16(input logic signed [SW-1:0] x);
    delay_t r;
    if (x < 0) begin
      r = '0;
    end else if (x > SAT_HI) begin
      r = DELAY_MAX;
    end else begin
      r = x[DELAY_W-1:0];
    end
    return r;
  endfunction

  logic [3:0] state;
  logic [AW-1:0] head;
  logic [CW-1:0] count;
  delay_t tick;
  id_t req_id;
  delay_t req_dly;
  logic [CW-1:0] pos;
  logic signed [SW-1:0] sum;
  delay_t old_d;
  delay_t newd;
  delay_t fol;
  logic [CW-1:0] sh_dst;
  id_t cur_id;
  logic [NRES_W-1:0] nres;
  kind_t e_kind;
  id_t e_id;

  logic out_valid;
  kind_t out_kind;
  id_t out_id;
  logic out_last;

  // List storage.
  delay_t delta_mem [DEPTH];
  id_t id_mem [DEPTH];
  delay_t rd_delta;
  id_t rd_id;

  logic [CW-1:0] rd_log;
  logic [CW-1:0] wr_log;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic we_delta;
  logic we_id;
  delay_t wr_delta;
  id_t wr_id;

  logic slot_free;
  logic load_out;
  logic front;
  logic signed [SW-1:0] walk_sum;
  logic walk_go;
  logic signed [SW-1:0] dly_s;
  logic signed [SW-1:0] old_s;
  logic signed [SW-1:0] newd_s;
  logic signed [SW-1:0] elapsed_s;
  delay_t tick_inc;
  logic more;

  assign req.ready = (state == ST_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.kind = out_kind;
  assign rsp.fired_id = out_id;
  assign rsp.last = out_last;

  assign slot_free = !out_valid || rsp.ready;
  assign load_out = slot_free && ((state == ST_EMIT) || (state == ST_POP));
  assign front = (pos == '0);

  // Shared add and compare for the walk.
  assign dly_s = signed'(SW'(req_dly));
  assign old_s = signed'(SW'(old_d));
  assign newd_s = signed'(SW'(newd));
  assign elapsed_s = front ? signed'(SW'(tick)) : '0;
  assign walk_sum = sum + signed'(SW'(rd_delta));
  assign walk_go = (pos < count) && (dly_s > walk_sum);

  assign tick_inc = (tick == DELAY_MAX) ? tick : tick + 1'b1;
  assign more = (count > CW'(1)) && (rd_delta == '0) &&
                ((NRES_W+1)'(nres) + 1'b1 < (NRES_W+1)'(MAX_RESULTS));

  // Read address for the next cycle's registered read.
  always_comb begin
    rd_log = '0;
    unique case (state)
      ST_WALK: rd_log = pos + 1'b1;
      ST_SHIFT_PRIME: rd_log = count - 1'b1;
      ST_SHIFT: rd_log = (sh_dst > pos + 1'b1) ? sh_dst - CW'(2) : '0;
      ST_TICK: rd_log = CW'(1);
      ST_POP: rd_log = slot_free ? CW'(2) : CW'(1);
      default: rd_log = '0;
    endcase
  end

  // Write port.
  always_comb begin
    we_delta = 1'b0;
    we_id = 1'b0;
    wr_log = pos;
    wr_delta = newd;
    wr_id = req_id;
    unique case (state)
      ST_SHIFT: begin
        we_delta = 1'b1;
        we_id = 1'b1;
        wr_log = sh_dst;
        wr_delta = rd_delta;
        wr_id = rd_id;
      end
      ST_WR_FOL: begin
        we_delta = 1'b1;
        wr_log = pos + 1'b1;
        wr_delta = fol;
      end
      ST_WR_NEW: begin
        we_delta = 1'b1;
        we_id = 1'b1;
      end
      default: begin
        we_delta = 1'b0;
      end
    endcase
  end

  assign rd_addr = phys(head, rd_log);
  assign wr_addr = phys(head, wr_log);

  // Delta and id memories.
  always_ff @(posedge clk) begin
    if (we_delta) begin
      delta_mem[wr_addr] <= wr_delta;
    end
    if (we_id) begin
      id_mem[wr_addr] <= wr_id;
    end
    rd_delta <= delta_mem[rd_addr];
    rd_id <= id_mem[rd_addr];
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      head <= '0;
      count <= '0;
      tick <= '0;
      out_valid <= 1'b0;
    end else begin
      // The output register fills from the emit and pop states, else drains.
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            req_id <= req.event_id;
            req_dly <= req.delay;
            pos <= '0;
            sum <= -signed'(SW'(tick));
            nres <= '0;
            if (req.req_type == REQ_ADD) begin
              if (req.delay == '0) begin
                e_kind <= KIND_FIRED;
                e_id <= req.event_id;
                state <= ST_EMIT;
              end else if (count == DEPTH_C) begin
                e_kind <= KIND_FULL;
                e_id <= '0;
                state <= ST_EMIT;
              end else begin
                state <= ST_WALK;
              end
            end else if (count == '0) begin
              e_kind <= KIND_NONE;
              e_id <= '0;
              state <= ST_EMIT;
            end else begin
              state <= ST_TICK;
            end
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_kind <= e_kind;
            out_id <= e_id;
            out_last <= 1'b1;
            state <= ST_IDLE;
          end
        end
        // Find the first entry whose remaining time covers the new delay.
        ST_WALK: begin
          if (walk_go) begin
            sum <= walk_sum;
            pos <= pos + 1'b1;
          end else begin
            old_d <= rd_delta;
            state <= ST_CALC_NEW;
          end
        end
        ST_CALC_NEW: begin
          newd <= front ? req_dly : sat16(dly_s - sum);
          state <= ST_CALC_FOL;
        end
        ST_CALC_FOL: begin
          fol <= sat16(old_s - newd_s - elapsed_s);
          if (pos < count) begin
            sh_dst <= count;
            state <= ST_SHIFT_PRIME;
          end else begin
            state <= ST_WR_NEW;
          end
        end
        ST_SHIFT_PRIME: begin
          state <= ST_SHIFT;
        end
        // Move entries one place back, from the tail down to the insert point.
        ST_SHIFT: begin
          if (sh_dst == pos + 1'b1) begin
            state <= ST_WR_FOL;
          end else begin
            sh_dst <= sh_dst - 1'b1;
          end
        end
        ST_WR_FOL: begin
          state <= ST_WR_NEW;
        end
        ST_WR_NEW: begin
          count <= count + 1'b1;
          if (front) begin
            tick <= '0;
          end
          e_kind <= KIND_ACCEPT;
          e_id <= '0;
          state <= ST_EMIT;
        end
        // Advance the counter and check the front entry.
        ST_TICK: begin
          if (tick_inc < rd_delta) begin
            tick <= tick_inc;
            e_kind <= KIND_NONE;
            e_id <= '0;
            state <= ST_EMIT;
          end else begin
            tick <= '0;
            cur_id <= rd_id;
            state <= ST_POP;
          end
        end
        // Fire the front and its zero-delta followers, up to MAX_RESULTS per tick.
        ST_POP: begin
          if (slot_free) begin
            out_kind <= KIND_FIRED;
            out_id <= cur_id;
            out_last <= !more;
            head <= phys(head, CW'(1));
            count <= count - 1'b1;
            nres <= nres + 1'b1;
            cur_id <= rd_id;
            if (!more) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[hw/rtl/dlq_checker.sv]
module dlq_checker import dlq_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input kind_t rsp_kind,
  input id_t rsp_fired_id,
  input logic rsp_last
);

  // No result word survives reset.
  a_reset_clears: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result word valid right after reset");

  // A stalled result word holds.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) &&
    $stable(rsp_fired_id) && $stable(rsp_last))
    else $error("stalled result word changed");

  // The block works on one request at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while the previous one is in work");

  // Only fired events may be followed by further results of the same request.
  a_only_fired_chain: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_kind != KIND_FIRED |-> rsp_last && rsp_fired_id == '0)
    else $error("non-fired result is not final or carries an id");

endmodule

bind delta_list_timer_queue dlq_checker u_dlq_checker (
  .clk(clk),
  .rst(rst),
  .req_valid(req.valid),
  .req_ready(req.ready),
  .rsp_valid(rsp.valid),
  .rsp_ready(rsp.ready),
  .rsp_kind(rsp.kind),
  .rsp_fired_id(rsp.fired_id),
  .rsp_last(rsp.last)
);
